/* rtl/trwl_pkg.sv */
// Shared types, codes and helpers for the ticket reader/writer lock manager.
package trwl_pkg;

   localparam int DEF_NUM_CPUS    = 8;
   localparam int DEF_TICKET_BITS = 8;
   localparam int MAX_RESULTS     = 9;

   // request codes
   localparam logic [2:0] FN_ACQ_EXCL = 3'd0;
   localparam logic [2:0] FN_ACQ_SHRD = 3'd1;
   localparam logic [2:0] FN_REL_EXCL = 3'd2;
   localparam logic [2:0] FN_REL_SHRD = 3'd3;
   localparam logic [2:0] FN_REL_CUR  = 3'd4;
   localparam logic [2:0] FN_QUERY    = 3'd5;

   // result event codes
   localparam logic [2:0] EV_NOW      = 3'd0;
   localparam logic [2:0] EV_QUEUED   = 3'd1;
   localparam logic [2:0] EV_RELEASED = 3'd2;
   localparam logic [2:0] EV_QUERY    = 3'd3;
   localparam logic [2:0] EV_ERROR    = 3'd4;
   localparam logic [2:0] EV_GRANTED  = 3'd5;

   // hold modes
   localparam logic [1:0] HOLD_NONE = 2'd0;
   localparam logic [1:0] HOLD_EXCL = 2'd1;
   localparam logic [1:0] HOLD_SHRD = 2'd2;

   typedef struct packed {
      logic [2:0] cpu;
      logic [2:0] func;
   } req_type;

   typedef struct packed {
      logic [2:0] target_cpu;
      logic [2:0] event_res;
      logic [1:0] granted_mode;
      logic       held_here;
      logic       shared_here;
      logic       last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_FIND,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic load_req;
      logic exec;
      logic scan;
      logic grant;
      logic flush;
   } ctrl_cmd_type;

   typedef struct packed {
      logic found;
      logic found_shared;
      logic shared_zero;
      logic room_next;
      logic out_free;
   } ctrl_status_type;

   function automatic rsp_type make_rsp(logic [2:0] who, logic [2:0] ev, logic [1:0] mode,
                                        logic lst);
      rsp_type r;
      r.target_cpu   = who;
      r.event_res    = ev;
      r.granted_mode = mode;
      r.held_here    = (mode != HOLD_NONE);
      r.shared_here  = (mode == HOLD_SHRD);
      r.last         = lst;
      return r;
   endfunction

endpackage

/* rtl/trwl_ctrl.sv */
// Controller state machine that sequences request handling and the grant walk.
module trwl_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  trwl_pkg::ctrl_status_type status,
   output trwl_pkg::ctrl_cmd_type    cmd
);

   trwl_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= trwl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         trwl_pkg::ST_IDLE: begin
            if (req_valid) state_in = trwl_pkg::ST_EXEC;
         end
         trwl_pkg::ST_EXEC: begin
            state_in = trwl_pkg::ST_SCAN;
         end
         trwl_pkg::ST_SCAN: begin
            state_in = trwl_pkg::ST_FIND;
         end
         trwl_pkg::ST_FIND: begin
            if (!status.found || (!status.found_shared && !status.shared_zero)) begin
               state_in = trwl_pkg::ST_FLUSH;
            end else if (status.out_free) begin
               if (status.found_shared && status.room_next) state_in = trwl_pkg::ST_SCAN;
               else state_in = trwl_pkg::ST_FLUSH;
            end
         end
         trwl_pkg::ST_FLUSH: begin
            if (status.out_free) state_in = trwl_pkg::ST_IDLE;
         end
         default: state_in = trwl_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         trwl_pkg::ST_IDLE: begin
            req_stall    = 1'b0;
            cmd.load_req = req_valid;
         end
         trwl_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         trwl_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         trwl_pkg::ST_FIND: begin
            cmd.grant = status.found && (status.found_shared || status.shared_zero)
                        && status.out_free;
         end
         trwl_pkg::ST_FLUSH: begin
            cmd.flush = status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   a_exec_from_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == trwl_pkg::ST_EXEC |-> $past(state_ff) == trwl_pkg::ST_IDLE)
      else $error("exec entered without an accepted transaction");

   a_flush_ends: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> state_ff == trwl_pkg::ST_IDLE)
      else $error("final result pushed but sequencer did not return to idle");

   a_grant_found: assert property (@(posedge clock) disable iff (reset)
      cmd.grant |-> status.found)
      else $error("grant issued with no matching waiter");

endmodule

/* rtl/trwl_dpath.sv */
// Datapath: lock state, per-processor hold and wait tables, result staging.
module trwl_dpath #(
   parameter int NUM_CPUS    = trwl_pkg::DEF_NUM_CPUS,
   parameter int TICKET_BITS = trwl_pkg::DEF_TICKET_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  trwl_pkg::req_type         req_data,
   input  trwl_pkg::ctrl_cmd_type    cmd,
   output trwl_pkg::ctrl_status_type status,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output trwl_pkg::rsp_type         rsp_data
);

   localparam int IDX_W = $clog2(NUM_CPUS);
   localparam int CNT_W = $clog2(NUM_CPUS + 1);
   localparam int N_W   = $clog2(trwl_pkg::MAX_RESULTS + 1);

   trwl_pkg::req_type       req_ff;
   logic [TICKET_BITS-1:0]  ticket_next_ff;
   logic [TICKET_BITS-1:0]  serving_ff;
   logic [CNT_W-1:0]        shared_cnt_ff;
   logic [1:0]              hold_ff [NUM_CPUS];
   logic [NUM_CPUS-1:0]     waiting_ff;
   logic [NUM_CPUS-1:0]     wshared_ff;
   logic [TICKET_BITS-1:0]  wticket_ff [NUM_CPUS];
   logic [NUM_CPUS-1:0]     match_ff;
   trwl_pkg::rsp_type       pend_ff;
   logic [N_W-1:0]          n_ff;
   logic                    rsp_valid_ff;
   trwl_pkg::rsp_type       rsp_data_ff;

   // request decode
   logic              in_range;
   logic [IDX_W-1:0]  idx;
   logic [1:0]        cur_mode;
   logic              cur_idle;
   logic [2:0]        eff_func;
   logic [2:0]        ans_ev;
   logic [1:0]        ans_mode;
   logic              do_hold;
   logic [1:0]        new_hold;
   logic              do_wait;
   logic              wait_shrd;
   logic              inc_next;
   logic              inc_serving;
   logic              inc_shared;
   logic              dec_shared;

   // grant search
   logic              found_any;
   logic [IDX_W-1:0]  found_idx;
   logic              found_shrd;
   logic              out_free;
   logic [NUM_CPUS-1:0] holding;

   always_comb begin
      in_range    = 32'(req_ff.cpu) < NUM_CPUS;
      idx         = IDX_W'(req_ff.cpu);
      cur_mode    = hold_ff[idx];
      cur_idle    = (cur_mode == trwl_pkg::HOLD_NONE) && !waiting_ff[idx];
      eff_func    = req_ff.func;
      ans_ev      = trwl_pkg::EV_ERROR;
      ans_mode    = trwl_pkg::HOLD_NONE;
      do_hold     = 1'b0;
      new_hold    = trwl_pkg::HOLD_NONE;
      do_wait     = 1'b0;
      wait_shrd   = 1'b0;
      inc_next    = 1'b0;
      inc_serving = 1'b0;
      inc_shared  = 1'b0;
      dec_shared  = 1'b0;
      if (req_ff.func == trwl_pkg::FN_REL_CUR) begin
         eff_func = (cur_mode == trwl_pkg::HOLD_SHRD) ? trwl_pkg::FN_REL_SHRD
                                                      : trwl_pkg::FN_REL_EXCL;
      end
      if (!in_range) begin
         ans_ev = trwl_pkg::EV_ERROR;
      end else if (eff_func == trwl_pkg::FN_QUERY) begin
         ans_ev   = trwl_pkg::EV_QUERY;
         ans_mode = cur_mode;
      end else if (eff_func == trwl_pkg::FN_ACQ_EXCL && cur_idle) begin
         inc_next = 1'b1;
         if (ticket_next_ff == serving_ff && shared_cnt_ff == '0) begin
            do_hold  = 1'b1;
            new_hold = trwl_pkg::HOLD_EXCL;
            ans_ev   = trwl_pkg::EV_NOW;
            ans_mode = trwl_pkg::HOLD_EXCL;
         end else begin
            do_wait = 1'b1;
            ans_ev  = trwl_pkg::EV_QUEUED;
         end
      end else if (eff_func == trwl_pkg::FN_ACQ_SHRD && cur_idle) begin
         if (ticket_next_ff == serving_ff) begin
            inc_shared = 1'b1;
            do_hold    = 1'b1;
            new_hold   = trwl_pkg::HOLD_SHRD;
            ans_ev     = trwl_pkg::EV_NOW;
            ans_mode   = trwl_pkg::HOLD_SHRD;
         end else begin
            do_wait   = 1'b1;
            wait_shrd = 1'b1;
            inc_next  = 1'b1;
            ans_ev    = trwl_pkg::EV_QUEUED;
         end
      end else if (eff_func == trwl_pkg::FN_REL_EXCL && cur_mode == trwl_pkg::HOLD_EXCL) begin
         do_hold     = 1'b1;
         inc_serving = 1'b1;
         ans_ev      = trwl_pkg::EV_RELEASED;
      end else if (eff_func == trwl_pkg::FN_REL_SHRD && cur_mode == trwl_pkg::HOLD_SHRD) begin
         do_hold    = 1'b1;
         dec_shared = (shared_cnt_ff != '0);
         ans_ev     = trwl_pkg::EV_RELEASED;
      end else begin
         ans_ev   = trwl_pkg::EV_ERROR;
         ans_mode = cur_mode;
      end
   end

   // lowest processor index wins among waiters on the served ticket
   always_comb begin
      found_idx = '0;
      for (int i = NUM_CPUS - 1; i >= 0; i--) begin
         if (match_ff[i]) found_idx = IDX_W'(i);
      end
      found_any  = |match_ff;
      found_shrd = wshared_ff[found_idx];
      for (int i = 0; i < NUM_CPUS; i++) begin
         holding[i] = (hold_ff[i] != trwl_pkg::HOLD_NONE);
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign status.found        = found_any;
   assign status.found_shared = found_shrd;
   assign status.shared_zero  = (shared_cnt_ff == '0);
   assign status.room_next    = n_ff < N_W'(trwl_pkg::MAX_RESULTS - 1);
   assign status.out_free     = out_free;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         ticket_next_ff <= '0;
         serving_ff     <= '0;
         shared_cnt_ff  <= '0;
         waiting_ff     <= '0;
         n_ff           <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < NUM_CPUS; i++) hold_ff[i] <= trwl_pkg::HOLD_NONE;
      end else begin
         if (cmd.exec) begin
            n_ff <= N_W'(1);
            if (inc_next) ticket_next_ff <= ticket_next_ff + 1'b1;
            if (inc_serving) serving_ff <= serving_ff + 1'b1;
            if (inc_shared) shared_cnt_ff <= shared_cnt_ff + 1'b1;
            if (dec_shared) shared_cnt_ff <= shared_cnt_ff - 1'b1;
            if (do_hold) hold_ff[idx] <= new_hold;
            if (do_wait) waiting_ff[idx] <= 1'b1;
         end else if (cmd.grant) begin
            n_ff                  <= n_ff + 1'b1;
            waiting_ff[found_idx] <= 1'b0;
            if (found_shrd) begin
               hold_ff[found_idx] <= trwl_pkg::HOLD_SHRD;
               shared_cnt_ff      <= shared_cnt_ff + 1'b1;
               serving_ff         <= serving_ff + 1'b1;
            end else begin
               hold_ff[found_idx] <= trwl_pkg::HOLD_EXCL;
            end
         end
         if (cmd.grant || cmd.flush) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) req_ff <= req_data;
      if (cmd.exec && do_wait) begin
         wshared_ff[idx] <= wait_shrd;
         wticket_ff[idx] <= ticket_next_ff;
      end
      if (cmd.scan) begin
         for (int i = 0; i < NUM_CPUS; i++) begin
            match_ff[i] <= waiting_ff[i] && (wticket_ff[i] == serving_ff);
         end
      end
      if (cmd.exec) begin
         pend_ff <= trwl_pkg::make_rsp(req_ff.cpu, ans_ev, ans_mode, 1'b0);
      end else if (cmd.grant) begin
         pend_ff <= trwl_pkg::make_rsp(3'(found_idx), trwl_pkg::EV_GRANTED,
                       found_shrd ? trwl_pkg::HOLD_SHRD : trwl_pkg::HOLD_EXCL, 1'b0);
      end
      // hand the staged result on; only the flush marks the end of the run
      if (cmd.grant) begin
         rsp_data_ff <= pend_ff;
      end else if (cmd.flush) begin
         rsp_data_ff <= trwl_pkg::make_rsp(pend_ff.target_cpu, pend_ff.event_res,
                                           pend_ff.granted_mode, 1'b1);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_shared_bound: assert property (@(posedge clock) disable iff (reset)
      shared_cnt_ff <= CNT_W'(NUM_CPUS))
      else $error("shared holder count exceeds processor count");

   a_wait_xor_hold: assert property (@(posedge clock) disable iff (reset)
      (waiting_ff & holding) == '0)
      else $error("processor both waiting and holding the lock");

   a_push_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.grant || cmd.flush) |-> out_free)
      else $error("result pushed over a stalled transaction");

   a_result_limit: assert property (@(posedge clock) disable iff (reset)
      n_ff <= N_W'(trwl_pkg::MAX_RESULTS))
      else $error("more results than the per-transaction limit");

endmodule

/* rtl/ticket_reader_writer_lock.sv */
// Ticket reader/writer lock manager: one request per transaction, answer then grants.
// Each accepted request yields one answer for the requester followed by up to
// eight grants to waiting processors, the last result flagged by last. After the
// request is taken it is executed and the grant walk runs: for each grant the
// walk first compares every waiter's ticket with the served ticket and then
// picks the lowest matching processor; it scans again only after a shared grant
// that does not reach the result limit, and a push waits while the result
// channel stalls. A new request is taken only after the final result of the
// previous one lands in the output register.
// No clearing pass follows reset; requests are taken in the first cycle after it.
module ticket_reader_writer_lock #(
   parameter int NUM_CPUS    = trwl_pkg::DEF_NUM_CPUS,
   parameter int TICKET_BITS = trwl_pkg::DEF_TICKET_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  trwl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output trwl_pkg::rsp_type rsp_data
);

   trwl_pkg::ctrl_cmd_type    cmd;
   trwl_pkg::ctrl_status_type status;

   trwl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   trwl_dpath #(
      .NUM_CPUS    (NUM_CPUS),
      .TICKET_BITS (TICKET_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
